/* sv/sbsm_pkg.sv */
// shared types and constants for the serial bank switch mapper
// no dependencies; imported by sbsm_step and serial_bank_switch_mapper_core
package sbsm_pkg;

  // configuration register indexes
  localparam logic [1:0] CFG_HIGH_PRG_EN   = 2'd0;
  localparam logic [1:0] CFG_SRAM_MASK     = 2'd1;
  localparam logic [1:0] CFG_RAM_EN_CTRL   = 2'd2;
  localparam logic [1:0] CFG_RAM_EN_AT_RST = 2'd3;

  // target register chosen by address bits 14:13
  localparam logic [1:0] SEL_CONTROL = 2'd0;
  localparam logic [1:0] SEL_CHR0    = 2'd1;
  localparam logic [1:0] SEL_CHR1    = 2'd2;
  localparam logic [1:0] SEL_PRG     = 2'd3;

  localparam logic [4:0] CONTROL_RESET = 5'h0C;
  localparam logic [4:0] SRAM_MASK_HI  = 5'h08;
  localparam logic [4:0] SRAM_MASK_ALL = 5'h18;
  localparam logic [1:0] HOLDOFF_LOAD  = 2'd3;
  localparam logic [2:0] SHIFT_LAST    = 3'd4;
  localparam logic       OP_WRITE      = 1'b0;

  typedef struct packed {
    logic        op;
    logic [15:0] address;
    logic [7:0]  value;
  } sbsm_in_t;

  typedef struct packed {
    logic [4:0] prg_bank_low;
    logic [4:0] prg_bank_high;
    logic [4:0] chr_bank_low;
    logic [4:0] chr_bank_high;
    logic [1:0] mirroring;
    logic [1:0] sram_bank;
    logic       ram_enabled;
    logic       write_ignored;
  } sbsm_out_t;

  typedef struct packed {
    logic       high_prg_bit_enable;
    logic [4:0] sram_bank_mask;
    logic       ram_enable_control;
    logic       ram_enable_at_reset;
  } sbsm_cfg_t;

  typedef struct packed {
    logic [4:0] shift_value;
    logic [2:0] shift_count;
    logic [4:0] control_reg;
    logic [4:0] chr_reg_zero;
    logic [4:0] chr_reg_one;
    logic [4:0] prg_reg;
    logic       high_prg_bit;
    logic [1:0] sram_bank_reg;
    logic       ram_enable_reg;
    logic [1:0] holdoff_count;
  } sbsm_state_t;

endpackage

/* sv/serial_bank_switch_mapper_core.sv */
// serial-loaded bank switch mapper, top level
// depends on sbsm_pkg and sbsm_step
//
// Each input transfer is a cpu write into mapper space or one cpu clock tick,
// and each gives exactly one result transfer carrying the prg and chr bank
// numbers, mirroring, sram bank, prg ram enable and a flag for a write dropped
// because it came within three ticks of the previous accepted write. The
// block takes one transfer per clock unless a result held by out_ready backs up
// into a full input register; a transfer lands in an input register, and the
// mapper state is updated and the mapping worked out as it moves into the result
// register. Both registers hold one transfer each, so a new input is still taken
// while a finished result waits on out_ready, as long as the input register is empty.
// Configuration writes land at once and are meant for idle periods only.
module serial_bank_switch_mapper_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  sbsm_pkg::sbsm_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output sbsm_pkg::sbsm_out_t out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [4:0]          cfg_wdata
);
  import sbsm_pkg::*;

  // mapper state after reset, with the straps at their reset values
  localparam sbsm_state_t STATE_RESET = '{
    shift_value:    5'd0,
    shift_count:    3'd0,
    control_reg:    CONTROL_RESET,
    chr_reg_zero:   5'd0,
    chr_reg_one:    5'd0,
    prg_reg:        5'd0,
    high_prg_bit:   1'b0,
    sram_bank_reg:  2'd0,
    ram_enable_reg: 1'b1,
    holdoff_count:  2'd0
  };

  // input stage
  logic        in_valid_r;
  sbsm_in_t    in_r;
  // result stage
  logic        out_valid_r;
  sbsm_out_t   out_r;
  // mapper state and straps
  sbsm_state_t state_r, state_nxt;
  sbsm_cfg_t   cfg_r;
  sbsm_out_t   res;
  logic        advance;
  logic        step_fire;

  // the result register frees when empty or drained this cycle
  assign advance   = !out_valid_r || out_ready;
  assign step_fire = in_valid_r && advance;
  assign in_ready  = !in_valid_r || advance;

  sbsm_step u_step (
    .cfg  (cfg_r),
    .cur  (state_r),
    .item (in_r),
    .nxt  (state_nxt),
    .res  (res)
  );

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
    if (in_ready && in_valid) in_r <= in_data;
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
    if (step_fire) out_r <= res;
  end

  // straps and mapper state; strap writes also reload the bits that follow them
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.high_prg_bit_enable <= 1'b0;
      cfg_r.sram_bank_mask      <= 5'd0;
      cfg_r.ram_enable_control  <= 1'b1;
      cfg_r.ram_enable_at_reset <= 1'b1;
      state_r                   <= STATE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_HIGH_PRG_EN: begin
          cfg_r.high_prg_bit_enable <= cfg_wdata[0];
          state_r.high_prg_bit      <= cfg_wdata[0];
        end
        CFG_SRAM_MASK: begin
          cfg_r.sram_bank_mask <= cfg_wdata;
        end
        CFG_RAM_EN_CTRL: begin
          cfg_r.ram_enable_control <= cfg_wdata[0];
        end
        CFG_RAM_EN_AT_RST: begin
          cfg_r.ram_enable_at_reset <= cfg_wdata[0];
          state_r.ram_enable_reg    <= cfg_wdata[0];
        end
        default: begin
          cfg_r <= cfg_r;
        end
      endcase
    end else if (step_fire) begin
      state_r <= state_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // the shifter never holds more than four bits between commits
  a_shift_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.shift_count <= SHIFT_LAST)
    else $error("shift count out of range");

  // an accepted write arms the hold-off window
  a_holdoff_armed: assert property (@(posedge clk) disable iff (!rst_n)
    step_fire && !cfg_we && in_r.op == OP_WRITE && !res.write_ignored
      |=> state_r.holdoff_count == HOLDOFF_LOAD)
    else $error("hold-off not loaded after accepted write");

  // a write is dropped only while the hold-off window is open
  a_ignore_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    step_fire && res.write_ignored
      |-> state_r.holdoff_count != 2'd0 && in_r.op == OP_WRITE)
    else $error("write dropped outside hold-off window");

  // a stalled input stage keeps its transfer
  a_input_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !advance |=> in_valid_r && $stable(in_r))
    else $error("input stage lost a transfer");

endmodule

/* sv/sbsm_step.sv */
// next-state and bank mapping logic for one write or tick
// depends on sbsm_pkg
module sbsm_step (
  input  sbsm_pkg::sbsm_cfg_t   cfg,
  input  sbsm_pkg::sbsm_state_t cur,
  input  sbsm_pkg::sbsm_in_t    item,
  output sbsm_pkg::sbsm_state_t nxt,
  output sbsm_pkg::sbsm_out_t   res
);
  import sbsm_pkg::*;

  logic [4:0] shifted;
  logic [4:0] sram_m;
  logic [4:0] sram_src;
  logic [4:0] hb;
  logic [4:0] p;
  logic [1:0] sel;
  logic       ignored;

  assign sel    = item.address[14:13];
  assign sram_m = (cfg.high_prg_bit_enable ? SRAM_MASK_HI : SRAM_MASK_ALL) & cfg.sram_bank_mask;
  assign shifted = cur.shift_value | (5'(item.value[0]) << cur.shift_count);

  always_comb begin
    nxt      = cur;
    ignored  = 1'b0;
    sram_src = cur.chr_reg_zero;
    if (item.op != OP_WRITE) begin
      if (cur.holdoff_count != 2'd0) nxt.holdoff_count = cur.holdoff_count - 2'd1;
    end else if (cur.holdoff_count != 2'd0) begin
      ignored = 1'b1;
    end else begin
      nxt.holdoff_count = HOLDOFF_LOAD;
      if (item.value[7]) begin
        // shifter reset: force 16k mode with fixed upper window
        nxt.control_reg = cur.control_reg | CONTROL_RESET;
        nxt.shift_value = '0;
        nxt.shift_count = '0;
      end else if (cur.shift_count != SHIFT_LAST) begin
        nxt.shift_value = shifted;
        nxt.shift_count = cur.shift_count + 3'd1;
      end else begin
        nxt.shift_value = '0;
        nxt.shift_count = '0;
        unique case (sel)
          SEL_CONTROL: begin
            nxt.control_reg = shifted;
          end
          SEL_CHR0: begin
            nxt.chr_reg_zero = shifted;
            sram_src = shifted;
            if (cfg.high_prg_bit_enable) nxt.high_prg_bit = shifted[4];
          end
          SEL_CHR1: begin
            nxt.chr_reg_one = shifted;
            sram_src = shifted;
            if (cfg.high_prg_bit_enable) nxt.high_prg_bit = shifted[4];
          end
          SEL_PRG: begin
            nxt.prg_reg = shifted;
            if (cfg.ram_enable_control) nxt.ram_enable_reg = ~shifted[4];
          end
          default: begin
            nxt.prg_reg = shifted;
          end
        endcase
        if (sel != SEL_PRG && sram_m != 5'd0) begin
          nxt.sram_bank_reg = 2'((sram_src & sram_m) >> 3);
        end
      end
    end
  end

  assign hb = {nxt.high_prg_bit, 4'd0};
  assign p  = {nxt.high_prg_bit, nxt.prg_reg[3:0]};

  always_comb begin
    res = '0;
    if (!nxt.control_reg[3]) begin
      res.prg_bank_low  = {p[4:1], 1'b0};
      res.prg_bank_high = {p[4:1], 1'b1};
    end else if (nxt.control_reg[2]) begin
      res.prg_bank_low  = p;
      res.prg_bank_high = hb | 5'h0F;
    end else begin
      res.prg_bank_low  = hb;
      res.prg_bank_high = p;
    end
    if (!nxt.control_reg[4]) begin
      res.chr_bank_low  = {nxt.chr_reg_zero[4:1], 1'b0};
      res.chr_bank_high = {nxt.chr_reg_zero[4:1], 1'b1};
    end else begin
      res.chr_bank_low  = nxt.chr_reg_zero;
      res.chr_bank_high = nxt.chr_reg_one;
    end
    res.mirroring     = nxt.control_reg[1:0];
    res.sram_bank     = nxt.sram_bank_reg;
    res.ram_enabled   = nxt.ram_enable_reg;
    res.write_ignored = ignored;
  end

endmodule

/* sim/testbench.sv */
// self-checking testbench for serial_bank_switch_mapper_core
// depends on sbsm_pkg and the mapper rtl; holds its own bank mapping predictor
// random valid/ready idling on both sides, several strap settings, directed start
module testbench;
  import sbsm_pkg::*;

  localparam logic OP_TICK     = ~OP_WRITE;
  localparam int   CYCLE_LIMIT = 400000;
  localparam int   SETTINGS_N  = 8;
  localparam int   PER_SETTING = 178;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  sbsm_in_t   in_data;
  logic       out_valid;
  logic       out_ready;
  sbsm_out_t  out_data;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic [4:0] cfg_wdata;

  serial_bank_switch_mapper_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // 2 time unit clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // mapping predictor: own copy of the straps and the mapper state
  // ---------------------------------------------------------------------------
  logic       strap_hi_en;
  logic [4:0] strap_sram_mask;
  logic       strap_ram_ctl;
  logic       strap_ram_rst;

  logic [4:0] ser_bits;     // serial shifter, lsb first
  int         ser_count;    // data bits taken so far
  logic [4:0] ctl;          // control: prg mode 3:2, chr mode 4, mirroring 1:0
  logic [4:0] chr_a;
  logic [4:0] chr_b;
  logic [4:0] prg_sel;
  logic       prg_top;      // upper prg half select on 512k boards
  logic [1:0] ram_bank;
  logic       ram_on;
  logic [1:0] busy_ticks;   // hold-off between accepted writes

  // mapping expected for each accepted input transfer, oldest first
  sbsm_out_t  pending_maps[$];

  int errors       = 0;
  int items_sent   = 0;
  int results_seen = 0;
  int cycles       = 0;
  int send_idle_pct;
  int take_idle_pct;

  // applies one cpu write or tick to the predictor and returns the mapping after it
  function automatic sbsm_out_t advance_mapper(input sbsm_in_t item);
    sbsm_out_t  r;
    logic [4:0] pb;
    logic [4:0] loaded;
    logic [4:0] m;
    logic [4:0] src;
    logic [1:0] sel;
    logic       dropped;
    dropped = 1'b0;
    sel     = item.address[14:13];
    if (item.op == OP_TICK) begin
      if (busy_ticks != 2'd0) busy_ticks = busy_ticks - 2'd1;
    end else if (busy_ticks != 2'd0) begin
      // write too soon after the previous accepted one
      dropped = 1'b1;
    end else begin
      busy_ticks = HOLDOFF_LOAD;
      if (item.value[7]) begin
        // reset write: clear the shifter and force 16k mode, fixed upper window
        ctl       = ctl | CONTROL_RESET;
        ser_bits  = '0;
        ser_count = 0;
      end else begin
        ser_bits[ser_count] = item.value[0];
        ser_count++;
        if (ser_count == 5) begin
          loaded    = ser_bits;
          ser_bits  = '0;
          ser_count = 0;
          case (sel)
            SEL_CONTROL: ctl   = loaded;
            SEL_CHR0:    chr_a = loaded;
            SEL_CHR1:    chr_b = loaded;
            default: begin
              prg_sel = loaded;
              if (strap_ram_ctl) ram_on = ~loaded[4];
            end
          endcase
          if (sel != SEL_PRG) begin
            // sram bank follows chr0, or chr1 on a chr1 write
            src = (sel == SEL_CONTROL) ? chr_a : loaded;
            m   = (strap_hi_en ? SRAM_MASK_HI : SRAM_MASK_ALL) & strap_sram_mask;
            if (m != '0) begin
              src      = (src & m) >> 3;
              ram_bank = src[1:0];
            end
            if (strap_hi_en && sel != SEL_CONTROL) prg_top = loaded[4];
          end
        end
      end
    end

    pb = {prg_top, prg_sel[3:0]};
    if (!ctl[3]) begin
      // 32k mode
      r.prg_bank_low  = {pb[4:1], 1'b0};
      r.prg_bank_high = {pb[4:1], 1'b1};
    end else if (ctl[2]) begin
      r.prg_bank_low  = pb;
      r.prg_bank_high = {prg_top, 4'hF};
    end else begin
      r.prg_bank_low  = {prg_top, 4'h0};
      r.prg_bank_high = pb;
    end
    if (!ctl[4]) begin
      // 8k chr mode
      r.chr_bank_low  = {chr_a[4:1], 1'b0};
      r.chr_bank_high = {chr_a[4:1], 1'b1};
    end else begin
      r.chr_bank_low  = chr_a;
      r.chr_bank_high = chr_b;
    end
    r.mirroring     = ctl[1:0];
    r.sram_bank     = ram_bank;
    r.ram_enabled   = ram_on;
    r.write_ignored = dropped;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // result side: random stalls on out_ready, every result transfer checked
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [4:0] want, input logic [4:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  task automatic check_result(input sbsm_out_t got);
    sbsm_out_t want;
    if (pending_maps.size() == 0) begin
      $display("%0t: result transfer with nothing expected, actual %p", $time, got);
      errors++;
    end else begin
      want = pending_maps.pop_front();
      check_field("prg_bank_low",  want.prg_bank_low,  got.prg_bank_low);
      check_field("prg_bank_high", want.prg_bank_high, got.prg_bank_high);
      check_field("chr_bank_low",  want.chr_bank_low,  got.chr_bank_low);
      check_field("chr_bank_high", want.chr_bank_high, got.chr_bank_high);
      check_field("mirroring",     5'(want.mirroring),     5'(got.mirroring));
      check_field("sram_bank",     5'(want.sram_bank),     5'(got.sram_bank));
      check_field("ram_enabled",   5'(want.ram_enabled),   5'(got.ram_enabled));
      check_field("write_ignored", 5'(want.write_ignored), 5'(got.write_ignored));
      results_seen++;
    end
  endtask

  // sample the handshake as it stood before the edge, then pick the next ready
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) check_result(out_data);
    out_ready <= ($urandom_range(99) >= take_idle_pct);
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still expected", cycles,
               pending_maps.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // one input transfer; valid stays up between back-to-back transfers
  task automatic send_item(input logic op, input logic [15:0] addr, input logic [7:0] val);
    sbsm_in_t item;
    item.op      = op;
    item.address = addr;
    item.value   = val;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_maps.push_back(advance_mapper(item));
    items_sent++;
  endtask

  // ticks carry random address and value, which the block must ignore
  task automatic send_ticks(input int n);
    repeat (n) send_item(OP_TICK, 16'($urandom_range(65535)), 8'($urandom_range(255)));
  endtask

  // drop valid, let every expected result drain, then allow the pipe to settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_maps.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // one register write; the caller lowers the write enable after the last one
  task automatic cfg_write(input logic [1:0] idx, input logic [4:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      CFG_HIGH_PRG_EN: begin
        strap_hi_en = data[0];
        prg_top     = data[0];
      end
      CFG_SRAM_MASK:   strap_sram_mask = data;
      CFG_RAM_EN_CTRL: strap_ram_ctl   = data[0];
      default: begin
        strap_ram_rst = data[0];
        ram_on        = data[0];
      end
    endcase
  endtask

  // single-bit straps get random upper bits, which must not matter
  task automatic apply_setting(input logic hi, input logic [4:0] mask, input logic rctl,
                               input logic rrst);
    logic [3:0] pad;
    pad = 4'($urandom_range(15));
    cfg_write(CFG_HIGH_PRG_EN, {pad, hi});
    cfg_write(CFG_SRAM_MASK, mask);
    pad = 4'($urandom_range(15));
    cfg_write(CFG_RAM_EN_CTRL, {pad, rctl});
    pad = 4'($urandom_range(15));
    cfg_write(CFG_RAM_EN_AT_RST, {pad, rrst});
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // mostly complete five-write loads with the proper hold-off, the rest noise
  task automatic run_mixed_traffic(input int upto);
    logic [1:0]  tgt;
    logic [15:0] addr;
    logic [7:0]  val;
    while (items_sent < upto) begin
      if ($urandom_range(99) < 75) begin
        if ($urandom_range(4) == 0) begin
          val    = 8'($urandom_range(255));
          val[7] = 1'b1;
          send_item(OP_WRITE, 16'($urandom_range(65535)), val);
          send_ticks(3);
        end
        tgt = 2'($urandom_range(3));
        repeat (5) begin
          addr        = 16'($urandom_range(65535));
          addr[14:13] = tgt;
          val         = 8'($urandom_range(255));
          val[7]      = 1'b0;
          send_item(OP_WRITE, addr, val);
          send_ticks(3 + (($urandom_range(9) == 0) ? 1 : 0));
        end
      end else begin
        // noise: stray writes, early writes and short tick runs
        case ($urandom_range(2))
          0: send_ticks($urandom_range(3));
          1: send_item(OP_WRITE, 16'($urandom_range(65535)), 8'($urandom_range(255)));
          default: begin
            send_item(OP_WRITE, 16'($urandom_range(65535)), 8'($urandom_range(255)));
            send_ticks($urandom_range(2));
            send_item(OP_WRITE, 16'($urandom_range(65535)), 8'($urandom_range(255)));
          end
        endcase
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset write, a write inside the hold-off window, ticks with junk payload
  task automatic test_holdoff_and_reset_write();
    send_item(OP_TICK, 16'hFFFF, 8'hFF);
    send_item(OP_WRITE, 16'h8000, 8'h80);
    send_item(OP_WRITE, 16'hFFFF, 8'h7F);
    send_ticks(3);
    send_item(OP_TICK, 16'h0000, 8'h00);
  endtask

  // full serial load of control with all ones: 16k fixed upper, 4k chr, horizontal
  task automatic test_control_load();
    for (int i = 0; i < 5; i++) begin
      send_item(OP_WRITE, (i % 2) ? 16'h9FFF : 16'h0000, (i % 2) ? 8'h7F : 8'h01);
      send_ticks(3);
    end
  endtask

  // strap settings including all-high, with the idling pattern changing
  task automatic test_strap_sweep();
    for (int s = 0; s < SETTINGS_N; s++) begin
      wait_idle();
      send_idle_pct = (s < 3) ? 18 : ((s < 6) ? 55 : 0);
      take_idle_pct = (s < 3) ? 55 : ((s < 6) ? 18 : 0);
      case (s)
        0: apply_setting(1'b0, 5'd0,  1'b1, 1'b1);
        1: apply_setting(1'b1, 5'd24, 1'b1, 1'b1);
        2: apply_setting(1'b0, 5'd24, 1'b0, 1'b0);
        3: apply_setting(1'b1, 5'd16, 1'b0, 1'b1);
        4: apply_setting(1'b0, 5'd8,  1'b1, 1'b0);
        5: apply_setting(1'b0, 5'd16, 1'b1, 1'b1);
        6: apply_setting(1'b1, 5'd8,  1'b1, 1'b0);
        default: apply_setting(1'($urandom_range(1)), 5'($urandom_range(24)),
                               1'($urandom_range(1)), 1'($urandom_range(1)));
      endcase
      run_mixed_traffic(items_sent + PER_SETTING);
    end
  endtask

  // ---------------------------------------------------------------------------
  // sequencing
  // ---------------------------------------------------------------------------
  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    out_ready     = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_wdata     = '0;
    send_idle_pct = 18;
    take_idle_pct = 55;

    // predictor straps and state as after reset
    strap_hi_en     = 1'b0;
    strap_sram_mask = '0;
    strap_ram_ctl   = 1'b1;
    strap_ram_rst   = 1'b1;
    ser_bits        = '0;
    ser_count       = 0;
    ctl             = CONTROL_RESET;
    chr_a           = '0;
    chr_b           = '0;
    prg_sel         = '0;
    prg_top         = strap_hi_en;
    ram_bank        = '0;
    ram_on          = strap_ram_rst;
    busy_ticks      = '0;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_holdoff_and_reset_write();
    test_control_load();
    test_strap_sweep();
    wait_idle();

    $display("sent %0d cpu writes and ticks, checked %0d mappings over %0d strap settings",
             items_sent, results_seen, SETTINGS_N);
    $display("idling ran sender-light, receiver-light and then with none at all");
    if (errors == 0 && pending_maps.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
